// ===== hw/rtl/smas_pkg.sv =====
// ---------------------------------------------------------------------------
// smas_pkg
// Shared types, codes and defaults of the stepwise sorter unit.
// ---------------------------------------------------------------------------
`default_nettype none

package smas_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int VALUE_BITS_DEF = 7;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_STEP = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    localparam logic [1:0] ALG_BUBBLE    = 2'd0;
    localparam logic [1:0] ALG_SELECTION = 2'd1;
    localparam logic [1:0] ALG_FIRST_INV = 2'd2;
    localparam logic [1:0] ALG_COCKTAIL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_A,
        ST_RD_C,
        ST_PR_A,
        ST_PR_B,
        ST_PR_C,
        ST_SL_RI,
        ST_SL_CI,
        ST_SL_CL,
        ST_SL_KA,
        ST_SL_KC,
        ST_SL_DEC,
        ST_CK_ST,
        ST_SW1,
        ST_SW2
    } state_t;

    typedef enum logic [1:0] {
        PH_CHECK,
        PH_BUBBLE,
        PH_COCK
    } phase_t;

    typedef enum logic [1:0] {
        WS_IN,
        WS_A,
        WS_B
    } wsel_t;

    typedef struct packed {
        logic  we;
        logic  cap_a;
        logic  cap_b;
        wsel_t wsel;
    } dp_cmd_t;

    typedef struct packed {
        logic a_gt_r;
        logic r_lt_b;
        logic b_lt_a;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smas_datapath.sv =====
// ---------------------------------------------------------------------------
// smas_datapath
// Value store with a registered read port, two operand registers and the
// comparators the controller steers.
// ---------------------------------------------------------------------------
`default_nettype none

module smas_datapath
    import smas_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
)
(
    input  wire logic                  clk,
    input  wire dp_cmd_t               cmd,
    input  wire logic [AW-1:0]         addr,
    input  wire logic [VALUE_BITS-1:0] val_in,
    output      dp_stat_t              stat,
    output      logic [VALUE_BITS-1:0] rdata
);

    logic [VALUE_BITS-1:0] mem [DEPTH];
    logic [VALUE_BITS-1:0] rdata_reg;
    logic [VALUE_BITS-1:0] va_reg;
    logic [VALUE_BITS-1:0] vb_reg;
    logic [VALUE_BITS-1:0] wdata;

    always_comb
    begin
        case (cmd.wsel)
            WS_A:    wdata = va_reg;
            WS_B:    wdata = vb_reg;
            default: wdata = val_in;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_a)
        begin
            va_reg <= rdata_reg;
        end
        if (cmd.cap_b)
        begin
            vb_reg <= rdata_reg;
        end
    end

    assign stat.a_gt_r = va_reg > rdata_reg;
    assign stat.r_lt_b = rdata_reg < vb_reg;
    assign stat.b_lt_a = vb_reg < va_reg;
    assign rdata       = rdata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/smas_ctrl.sv =====
// ---------------------------------------------------------------------------
// smas_ctrl
// Sequencer: scan positions, scheme state, highlight marks and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module smas_ctrl
    import smas_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int AW         = $clog2(DEPTH)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_data,
    input  wire logic                  in_valid,
    output      logic                  in_ready,
    input  wire logic [1:0]            in_mode,
    input  wire logic [5:0]            in_index,
    input  wire logic [6:0]            in_value,
    output      logic                  out_valid,
    input  wire logic                  out_ready,
    output      logic [31:0]           out_data,
    output      dp_cmd_t               cmd,
    output      logic [AW-1:0]         addr,
    output      logic [VALUE_BITS-1:0] val_out,
    input  wire dp_stat_t              stat,
    input  wire logic [VALUE_BITS-1:0] rdata
);

    localparam int TW = AW + 1;
    localparam logic [AW-1:0] LAST_PAIR = AW'(DEPTH - 2);
    localparam logic [AW-1:0] LAST_POS  = AW'(DEPTH - 1);
    localparam logic [TW-1:0] DEPTH_T   = TW'(DEPTH);

    state_t        state_reg,  state_next;
    phase_t        phase_reg,  phase_next;
    logic [1:0]    alg_reg,    alg_next;
    logic [5:0]    idx_reg,    idx_next;
    logic [6:0]    val_reg,    val_next;
    logic [AW-1:0] pa_reg,     pa_next;
    logic [AW-1:0] pb_reg,     pb_next;
    logic [TW-1:0] k_reg,      k_next;
    logic [AW-1:0] outer_reg,  outer_next;
    logic [AW-1:0] inner_reg,  inner_next;
    logic          back_reg,   back_next;
    logic [TW-1:0] tail_reg,   tail_next;
    logic [7:0]    mark1_reg,  mark1_next;
    logic [7:0]    mark2_reg,  mark2_next;
    logic          swp_reg,    swp_next;
    logic          done_reg,   done_next;
    logic [6:0]    rd_reg,     rd_next;
    logic          ovalid_reg, ovalid_next;
    logic [31:0]   odata_reg,  odata_next;

    logic          idx_ok;
    logic [AW-1:0] pa_inc;
    logic [TW-1:0] turn_tail;
    logic [TW-1:0] turn_j;

    assign idx_ok    = 32'(idx_reg) < DEPTH;
    assign pa_inc    = pa_reg + AW'(1);
    assign turn_tail = (tail_reg < DEPTH_T) ? tail_reg + TW'(1) : tail_reg;
    assign turn_j    = DEPTH_T - turn_tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            phase_reg  <= PH_CHECK;
            alg_reg    <= ALG_BUBBLE;
            outer_reg  <= '0;
            inner_reg  <= '0;
            back_reg   <= 1'b0;
            tail_reg   <= TW'(1);
            mark1_reg  <= 8'd0;
            mark2_reg  <= 8'd1;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            alg_reg    <= alg_next;
            outer_reg  <= outer_next;
            inner_reg  <= inner_next;
            back_reg   <= back_next;
            tail_reg   <= tail_next;
            mark1_reg  <= mark1_next;
            mark2_reg  <= mark2_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg   <= idx_next;
        val_reg   <= val_next;
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        k_reg     <= k_next;
        swp_reg   <= swp_next;
        done_reg  <= done_next;
        rd_reg    <= rd_next;
        odata_reg <= odata_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        alg_next    = alg_reg;
        idx_next    = idx_reg;
        val_next    = val_reg;
        pa_next     = pa_reg;
        pb_next     = pb_reg;
        k_next      = k_reg;
        outer_next  = outer_reg;
        inner_next  = inner_reg;
        back_next   = back_reg;
        tail_next   = tail_reg;
        mark1_next  = mark1_reg;
        mark2_next  = mark2_reg;
        swp_next    = swp_reg;
        done_next   = done_reg;
        rd_next     = rd_reg;
        ovalid_next = ovalid_reg;
        odata_next  = odata_reg;
        cmd.we      = 1'b0;
        cmd.cap_a   = 1'b0;
        cmd.cap_b   = 1'b0;
        cmd.wsel    = WS_IN;
        addr        = pa_reg;
        in_ready    = 1'b0;

        if (cfg_valid)
        begin
            alg_next = cfg_data;
        end

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    idx_next  = in_index;
                    val_next  = in_value;
                    swp_next  = 1'b0;
                    done_next = 1'b0;
                    rd_next   = 7'd0;
                    case (in_mode)
                        MODE_LOAD: state_next = ST_LOAD;
                        MODE_READ: state_next = ST_RD_A;
                        MODE_STEP:
                        begin
                            pa_next    = '0;
                            phase_next = PH_CHECK;
                            state_next = ST_PR_A;
                        end
                        default:   state_next = ST_SW2;
                    endcase
                end
            end

            ST_LOAD:
            begin
                addr     = AW'(idx_reg);
                cmd.wsel = WS_IN;
                if (idx_ok)
                begin
                    cmd.we     = 1'b1;
                    outer_next = '0;
                    inner_next = '0;
                    back_next  = 1'b0;
                    tail_next  = TW'(1);
                    mark1_next = 8'd0;
                    mark2_next = 8'd1;
                end
                state_next = ST_SW2;
            end

            ST_RD_A:
            begin
                addr       = AW'(idx_reg);
                state_next = ST_RD_C;
            end

            ST_RD_C:
            begin
                rd_next    = idx_ok ? 7'(rdata) : 7'd0;
                state_next = ST_SW2;
            end

            ST_PR_A:
            begin
                addr       = pa_reg;
                state_next = ST_PR_B;
            end

            ST_PR_B:
            begin
                cmd.cap_a  = 1'b1;
                addr       = pa_inc;
                state_next = ST_PR_C;
            end

            ST_PR_C:
            begin
                cmd.cap_b = 1'b1;
                pb_next   = pa_inc;
                case (phase_reg)
                    PH_CHECK:
                    begin
                        if (stat.a_gt_r)
                        begin
                            case (alg_reg)
                                ALG_BUBBLE:
                                begin
                                    pa_next    = (inner_reg > LAST_PAIR) ? '0 : inner_reg;
                                    phase_next = PH_BUBBLE;
                                    state_next = ST_PR_A;
                                end
                                ALG_SELECTION:
                                begin
                                    pa_next    = (outer_reg > LAST_PAIR) ? '0 : outer_reg;
                                    state_next = ST_SL_RI;
                                end
                                ALG_FIRST_INV:
                                begin
                                    // the scan stopped on the lowest inversion
                                    mark1_next = 8'(pa_reg) - 8'd1;
                                    mark2_next = 8'(pa_reg);
                                    outer_next = '0;
                                    inner_next = '0;
                                    state_next = ST_SW1;
                                end
                                default:
                                begin
                                    pa_next    = inner_reg;
                                    phase_next = PH_COCK;
                                    state_next = ST_CK_ST;
                                end
                            endcase
                        end
                        else if (pa_reg == LAST_PAIR)
                        begin
                            done_next  = 1'b1;
                            state_next = ST_SW2;
                        end
                        else
                        begin
                            pa_next    = pa_inc;
                            state_next = ST_PR_A;
                        end
                    end

                    PH_BUBBLE:
                    begin
                        if (stat.a_gt_r)
                        begin
                            mark1_next = 8'(pa_reg) + 8'd1;
                            mark2_next = 8'(pa_reg) + 8'd2;
                            inner_next = pa_reg;
                            state_next = ST_SW1;
                        end
                        else
                        begin
                            pa_next    = (pa_reg >= LAST_PAIR) ? '0 : pa_inc;
                            state_next = ST_PR_A;
                        end
                    end

                    default:
                    begin
                        if (stat.a_gt_r)
                        begin
                            if (back_reg)
                            begin
                                mark1_next = 8'(pa_reg) - 8'd1;
                                mark2_next = 8'(pa_reg);
                            end
                            else
                            begin
                                mark1_next = 8'(pa_reg) + 8'd1;
                                mark2_next = 8'(pa_reg) + 8'd2;
                            end
                            inner_next = pa_reg;
                            state_next = ST_SW1;
                        end
                        else
                        begin
                            if (!back_reg)
                            begin
                                pa_next = pa_inc;
                            end
                            else if (pa_reg == '0)
                            begin
                                back_next = 1'b0;
                            end
                            else
                            begin
                                pa_next = pa_reg - AW'(1);
                            end
                            state_next = ST_CK_ST;
                        end
                    end
                endcase
            end

            ST_CK_ST:
            begin
                if (!back_reg)
                begin
                    if (pa_reg >= LAST_POS)
                    begin
                        // turn at the top: grow the sorted tail, start backward
                        tail_next = turn_tail;
                        pa_next   = turn_j[AW-1:0];
                        back_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_PR_A;
                    end
                end
                else
                begin
                    if (pa_reg > LAST_PAIR)
                    begin
                        pa_next = LAST_PAIR;
                    end
                    state_next = ST_PR_A;
                end
            end

            ST_SL_RI:
            begin
                addr       = pa_reg;
                state_next = ST_SL_CI;
            end

            ST_SL_CI:
            begin
                cmd.cap_a  = 1'b1;
                addr       = pa_inc;
                state_next = ST_SL_CL;
            end

            ST_SL_CL:
            begin
                cmd.cap_b  = 1'b1;
                pb_next    = pa_inc;
                k_next     = TW'(pa_reg) + TW'(2);
                state_next = (TW'(pa_reg) + TW'(2) == DEPTH_T) ? ST_SL_DEC : ST_SL_KA;
            end

            ST_SL_KA:
            begin
                addr       = k_reg[AW-1:0];
                state_next = ST_SL_KC;
            end

            ST_SL_KC:
            begin
                if (stat.r_lt_b)
                begin
                    cmd.cap_b = 1'b1;
                    pb_next   = k_reg[AW-1:0];
                end
                k_next     = k_reg + TW'(1);
                state_next = (k_reg + TW'(1) == DEPTH_T) ? ST_SL_DEC : ST_SL_KA;
            end

            ST_SL_DEC:
            begin
                if (stat.b_lt_a)
                begin
                    mark1_next = 8'(pb_reg);
                    mark2_next = 8'(pa_reg);
                    outer_next = pa_reg;
                    state_next = ST_SW1;
                end
                else
                begin
                    pa_next    = (pa_reg >= LAST_PAIR) ? '0 : pa_inc;
                    state_next = ST_SL_RI;
                end
            end

            ST_SW1:
            begin
                cmd.we     = 1'b1;
                cmd.wsel   = WS_B;
                addr       = pa_reg;
                swp_next   = 1'b1;
                state_next = ST_SW2;
            end

            ST_SW2:
            begin
                // second half of an exchange, repeated harmlessly while the output stalls
                if (swp_reg)
                begin
                    cmd.we   = 1'b1;
                    cmd.wsel = WS_A;
                    addr     = pb_reg;
                end
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next = 1'b1;
                    odata_next  = {7'd0, rd_reg, done_reg, swp_reg, mark2_reg, mark1_reg};
                    state_next  = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign val_out   = VALUE_BITS'(val_reg);
    assign out_valid = ovalid_reg;
    assign out_data  = odata_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/stepwise_multi_algorithm_sorter_unit.sv =====
// A load passes ST_LOAD and ST_SW2, a read passes ST_RD_A, ST_RD_C and ST_SW2 before its result.
// A step first checks order pair by pair (ST_PR_A, ST_PR_B, ST_PR_C); a sorted store reports done.
// Then bubble scans pair by pair, cocktail scans forward and backward and turns at each end, and
// selection scans the entries after each head for the least; an exchange writes twice (one memory port).
// One item is worked at a time.
// Reset (rst_n low, asynchronous) clears scan state and marks; the store is undefined.
// ---------------------------------------------------------------------------
// stepwise_multi_algorithm_sorter_unit
// Stream front end joining the sequencer and the value store datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module stepwise_multi_algorithm_sorter_unit
    import smas_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_data,      // algorithm
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // index[5:0], value[12:6], zero pad
    input  wire logic [1:0]  s_axis_tuser,  // mode
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [31:0] m_axis_tdata   // first_mark, second_mark, swapped,
                                            // done_res, read_data, zero pad
);

    localparam int AW = $clog2(DEPTH);

    dp_cmd_t               cmd;
    dp_stat_t              stat;
    logic [AW-1:0]         addr;
    logic [VALUE_BITS-1:0] val_w;
    logic [VALUE_BITS-1:0] rdata;

    assign cfg_ready = 1'b1;

    smas_ctrl #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_mode   (s_axis_tuser),
        .in_index  (s_axis_tdata[5:0]),
        .in_value  (s_axis_tdata[12:6]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .cmd       (cmd),
        .addr      (addr),
        .val_out   (val_w),
        .stat      (stat),
        .rdata     (rdata)
    );

    smas_datapath #(
        .DEPTH      (DEPTH),
        .VALUE_BITS (VALUE_BITS),
        .AW         (AW)
    ) u_dp (
        .clk    (clk),
        .cmd    (cmd),
        .addr   (addr),
        .val_in (val_w),
        .stat   (stat),
        .rdata  (rdata)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/smas_checker.sv =====
// ---------------------------------------------------------------------------
// smas_checker
// Port-level checks of the sorter unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module smas_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_data,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [15:0] s_axis_tdata,
    input wire logic [1:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata
);

    // one transaction at a time: busy right after accepting
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while a transaction is in work");

    a_swap_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[16] && m_axis_tdata[17]))
        else $error("result flags both swap and done");

    a_swap_no_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[16] |-> m_axis_tdata[24:18] == 7'd0)
        else $error("swap result carries read data");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind stepwise_multi_algorithm_sorter_unit smas_checker u_smas_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_stepwise_multi_algorithm_sorter_unit.sv =====
// ---------------------------------------------------------------------------
// tb_stepwise_multi_algorithm_sorter_unit
// Loads the value store, then drives sort steps, reads and reloads under all
// four sort schemes with random stalls on both streams. A cycle-free sorter
// model predicts each result, and the monitor compares results in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_stepwise_multi_algorithm_sorter_unit
    import smas_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_ENTRIES = DEPTH_DEF;
    localparam int IDLE_LIMIT  = 400000;
    localparam int CFG_SETTLE  = 6;
    localparam int HOLD_CYCLES = 300;

    typedef enum logic [2:0] { K_ITEM, K_CFG, K_DRAIN, K_HOLD, K_QUIET } job_kind_t;

    typedef struct {
        job_kind_t  kind;
        logic [1:0] mode;
        logic [5:0] index;
        logic [6:0] value;
        logic [1:0] alg;
    } job_t;

    typedef struct {
        logic [7:0] first_mark;
        logic [7:0] second_mark;
        logic       swapped;
        logic       done_res;
        logic [6:0] read_data;
    } sort_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // index[5:0], value[12:6], zero pad
    logic [1:0]  s_axis_tuser = '0;   // mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // first_mark, second_mark, swapped, done_res, read_data

    logic        hold_go = 1'b0;
    logic        quiet = 1'b0;

    job_t         pending_items[$];
    sort_result_t expected_results[$];

    // sorter model state
    logic [6:0] model_store[NUM_ENTRIES];
    int         head_pos;
    int         scan_pos;
    bit         reverse_pass;
    int         tail_len;
    int         mark_a;
    int         mark_b;
    logic [1:0] scheme;

    int errors = 0;
    int results_seen = 0;
    int steps_done = 0;
    int steps_swapped = 0;
    int cfg_writes = 0;
    int idle_cycles = 0;

    int driver_gap = 0;
    int cfg_settle = 0;
    int stall_left = 0;
    int hold_left = 0;

    stepwise_multi_algorithm_sorter_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    function automatic void restart_scan();
        head_pos = 0;
        scan_pos = 0;
        reverse_pass = 0;
        tail_len = 1;
        mark_a = 0;
        mark_b = 1;
    endfunction

    function automatic bit store_ordered();
        for (int q = 0; q + 1 < NUM_ENTRIES; q++)
        begin
            if (model_store[q] > model_store[q + 1])
                return 0;
        end
        return 1;
    endfunction

    function automatic void swap_entries(int x, int y);
        logic [6:0] t;
        t = model_store[x];
        model_store[x] = model_store[y];
        model_store[y] = t;
    endfunction

    function automatic bit bubble_step();
        int j;
        j = scan_pos;
        if (j >= NUM_ENTRIES - 1)
            j = 0;
        for (int n = 0; n < 2 * NUM_ENTRIES + 2; n++)
        begin
            mark_a = j + 1;
            mark_b = j + 2;
            if (model_store[j] > model_store[j + 1])
            begin
                swap_entries(j, j + 1);
                scan_pos = j;
                return 1;
            end
            j++;
            if (j >= NUM_ENTRIES - 1)
                j = 0;
        end
        scan_pos = j;
        return 0;
    endfunction

    function automatic bit selection_step();
        int i;
        int pos;
        logic [6:0] least;
        i = head_pos;
        if (i >= NUM_ENTRIES - 1)
            i = 0;
        for (int n = 0; n < 2 * NUM_ENTRIES + 2; n++)
        begin
            pos = i + 1;
            least = model_store[pos];
            for (int k = i + 2; k < NUM_ENTRIES; k++)
            begin
                if (model_store[k] < least)
                begin
                    least = model_store[k];
                    pos = k;
                end
            end
            if (least < model_store[i])
            begin
                swap_entries(i, pos);
                mark_a = pos;
                mark_b = i;
                head_pos = i;
                return 1;
            end
            i++;
            if (i >= NUM_ENTRIES - 1)
                i = 0;
        end
        head_pos = i;
        return 0;
    endfunction

    function automatic bit first_inversion_step();
        for (int j = 0; j + 1 < NUM_ENTRIES; j++)
        begin
            if (model_store[j] > model_store[j + 1])
            begin
                swap_entries(j, j + 1);
                mark_a = j - 1;
                mark_b = j;
                head_pos = 0;
                scan_pos = 0;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic bit cocktail_step();
        int j;
        j = scan_pos;
        for (int n = 0; n < 4 * NUM_ENTRIES + 4; n++)
        begin
            if (!reverse_pass)
            begin
                if (j >= NUM_ENTRIES - 1)
                begin
                    if (tail_len < NUM_ENTRIES)
                        tail_len++;
                    j = NUM_ENTRIES - tail_len;
                    reverse_pass = 1;
                end
                else
                begin
                    mark_a = j + 1;
                    mark_b = j + 2;
                    if (model_store[j] > model_store[j + 1])
                    begin
                        swap_entries(j, j + 1);
                        scan_pos = j;
                        return 1;
                    end
                    j++;
                end
            end
            else
            begin
                if (j > NUM_ENTRIES - 2)
                    j = NUM_ENTRIES - 2;
                mark_a = j - 1;
                mark_b = j;
                if (model_store[j] > model_store[j + 1])
                begin
                    swap_entries(j, j + 1);
                    scan_pos = j;
                    return 1;
                end
                if (j == 0)
                    reverse_pass = 0;
                else
                    j--;
            end
        end
        scan_pos = j;
        return 0;
    endfunction

    function automatic sort_result_t apply_sort_item(job_t it);
        sort_result_t r;
        r.swapped = 0;
        r.done_res = 0;
        r.read_data = '0;
        if (it.mode == MODE_LOAD)
        begin
            model_store[it.index] = it.value;
            restart_scan();
        end
        else if (it.mode == MODE_READ)
            r.read_data = model_store[it.index];
        else if (it.mode == MODE_STEP)
        begin
            if (store_ordered())
                r.done_res = 1;
            else
            begin
                case (scheme)
                    ALG_BUBBLE:    r.swapped = bubble_step();
                    ALG_SELECTION: r.swapped = selection_step();
                    ALG_FIRST_INV: r.swapped = first_inversion_step();
                    default:       r.swapped = cocktail_step();
                endcase
            end
        end
        r.first_mark = mark_a[7:0];
        r.second_mark = mark_b[7:0];
        return r;
    endfunction

    // Driver: accept, predict, then offer the next pending job
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit   nv;
        bit   ncv;
        bit   hg;
        job_t j;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            cfg_valid <= 1'b0;
            hold_go <= 1'b0;
        end
        else
        begin
            nv = s_axis_tvalid;
            ncv = cfg_valid;
            hg = 0;
            if (s_axis_tvalid && s_axis_tready)
            begin
                j.kind = K_ITEM;
                j.mode = s_axis_tuser;
                j.index = s_axis_tdata[5:0];
                j.value = s_axis_tdata[12:6];
                expected_results.push_back(apply_sort_item(j));
                nv = 0;
            end
            if (cfg_valid && cfg_ready)
            begin
                scheme = cfg_data;
                cfg_writes++;
                ncv = 0;
            end
            if (!nv && !ncv)
            begin
                if (driver_gap > 0)
                    driver_gap--;
                else if (pending_items.size() > 0)
                begin
                    case (pending_items[0].kind)
                        K_ITEM:
                        begin
                            j = pending_items.pop_front();
                            s_axis_tdata <= {3'b000, j.value, j.index};
                            s_axis_tuser <= j.mode;
                            nv = 1;
                            if (!quiet && $urandom_range(3) == 0)
                                driver_gap = $urandom_range(1, 4);
                        end
                        K_CFG:
                        begin
                            // write only once the block has gone idle
                            if (expected_results.size() != 0)
                                cfg_settle = 0;
                            else if (cfg_settle < CFG_SETTLE)
                                cfg_settle++;
                            else
                            begin
                                j = pending_items.pop_front();
                                cfg_data <= j.alg;
                                ncv = 1;
                                cfg_settle = 0;
                            end
                        end
                        K_DRAIN:
                        begin
                            if (expected_results.size() == 0)
                                void'(pending_items.pop_front());
                        end
                        K_HOLD:
                        begin
                            void'(pending_items.pop_front());
                            hg = 1;
                        end
                        default:
                        begin
                            void'(pending_items.pop_front());
                            quiet <= 1'b1;
                        end
                    endcase
                end
            end
            s_axis_tvalid <= nv;
            cfg_valid <= ncv;
            hold_go <= hg;
        end
    end

    // Receiver backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
            hold_left <= 0;
        end
        else if (hold_go)
        begin
            hold_left <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_axis_tready <= (hold_left == 1);
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= (stall_left == 1);
        end
        else if (!quiet && $urandom_range(4) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin : monitor
        sort_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result transaction %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (e.done_res)
                    steps_done++;
                if (e.swapped)
                    steps_swapped++;
                if (m_axis_tdata[7:0] !== e.first_mark)
                begin
                    $error("first_mark: expected %0d, got %0d", $signed(e.first_mark),
                        $signed(m_axis_tdata[7:0]));
                    errors++;
                end
                if (m_axis_tdata[15:8] !== e.second_mark)
                begin
                    $error("second_mark: expected %0d, got %0d", $signed(e.second_mark),
                        $signed(m_axis_tdata[15:8]));
                    errors++;
                end
                if (m_axis_tdata[16] !== e.swapped)
                begin
                    $error("swapped: expected %0b, got %0b", e.swapped, m_axis_tdata[16]);
                    errors++;
                end
                if (m_axis_tdata[17] !== e.done_res)
                begin
                    $error("done_res: expected %0b, got %0b", e.done_res, m_axis_tdata[17]);
                    errors++;
                end
                if (m_axis_tdata[24:18] !== e.read_data)
                begin
                    $error("read_data: expected %0d, got %0d", e.read_data,
                        m_axis_tdata[24:18]);
                    errors++;
                end
            end
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_item(logic [1:0] mode, logic [5:0] idx, logic [6:0] val);
        job_t j;
        j.kind = K_ITEM;
        j.mode = mode;
        j.index = idx;
        j.value = val;
        j.alg = '0;
        pending_items.push_back(j);
    endtask

    task automatic add_job(job_kind_t k, logic [1:0] alg);
        job_t j;
        j.kind = k;
        j.mode = '0;
        j.index = '0;
        j.value = '0;
        j.alg = alg;
        pending_items.push_back(j);
    endtask

    initial
    begin : stimulus
        logic [1:0] plan[12];
        int         vmax;
        int         nsteps;
        plan = '{ALG_SELECTION, ALG_FIRST_INV, ALG_COCKTAIL, ALG_BUBBLE, ALG_COCKTAIL,
                 ALG_SELECTION, ALG_FIRST_INV, ALG_BUBBLE, ALG_COCKTAIL, ALG_SELECTION,
                 ALG_FIRST_INV, ALG_COCKTAIL};
        scheme = ALG_BUBBLE;
        restart_scan();
        for (int q = 0; q < NUM_ENTRIES; q++)
            model_store[q] = '0;

        // Directed: sorted fill, done step, extremes, ignored mode, first inversion
        add_job(K_CFG, ALG_BUBBLE);
        for (int q = 0; q < NUM_ENTRIES; q++)
            add_item(MODE_LOAD, q[5:0], 7'(2 * q));
        add_item(MODE_STEP, '0, '0);
        add_item(MODE_READ, 6'd0, '0);
        add_item(MODE_READ, 6'd63, 7'h7f);
        add_item(2'd3, 6'd63, 7'h7f);
        add_item(MODE_LOAD, 6'd63, 7'h7f);
        add_item(MODE_STEP, '0, '0);
        add_item(MODE_LOAD, 6'd0, 7'h7f);
        for (int q = 0; q < 6; q++)
            add_item(MODE_STEP, '0, '0);
        add_item(MODE_READ, 6'd1, '0);

        // Random phases, one scheme each; some switch scheme mid-scan
        for (int p = 0; p < 12; p++)
        begin
            add_job(K_DRAIN, '0);
            add_job(K_CFG, plan[p]);
            if (p == 11)
                add_job(K_QUIET, '0);
            vmax = ($urandom_range(3) == 0) ? 3 : 127;
            if (p == 0 || $urandom_range(2) != 0)
            begin
                for (int q = $urandom_range(4, 14); q > 0; q--)
                    add_item(MODE_LOAD, 6'($urandom_range(63)), 7'($urandom_range(vmax)));
            end
            if (p == 2)
                add_job(K_HOLD, '0);
            nsteps = $urandom_range(40, 80);
            for (int q = 0; q < nsteps; q++)
            begin
                case ($urandom_range(39))
                    0:       add_item(MODE_LOAD, 6'($urandom_range(63)),
                                 7'($urandom_range(vmax)));
                    1:       add_item(2'd3, 6'($urandom_range(63)), 7'($urandom));
                    2, 3, 4: add_item(MODE_READ, 6'($urandom_range(63)), 7'($urandom));
                    default: add_item(MODE_STEP, 6'($urandom), 7'($urandom));
                endcase
            end
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_items.size() == 0 && !s_axis_tvalid && !cfg_valid
              && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        $display("Checked %0d results over %0d scheme writes: %0d swap steps, %0d done steps.",
            results_seen, cfg_writes, steps_swapped, steps_done);
        if (errors == 0 && expected_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
